### hdl/sbpm_pkg.sv
// Package for the spectrum band peak meter: item types, command and status
// structs, function and register codes, and the bin-to-band map.
// No dependencies.
`timescale 1ns / 1ps

package sbpm_pkg;

  localparam int NUM_BANDS = 8;
  localparam int BAND_W    = $clog2(NUM_BANDS);
  localparam int MAG_W     = 24;
  localparam int LVL_W     = 8;
  localparam int MS_W      = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(MAG_W);

  // Input function codes.
  localparam logic [1:0] FUNC_BIN   = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_FRAME = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_NOISE_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LVL_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PEAK_STEP  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_HIGH  = 3'd6;

  // Register reset values.
  localparam logic [MAG_W-1:0] RST_NOISE_THR = 24'd500;
  localparam logic [15:0]      RST_TIMEOUT   = 16'd135;
  localparam logic [LVL_W-1:0] RST_LVL_LIMIT = 8'd200;
  localparam logic [LVL_W-1:0] RST_LVL_STEP  = 8'd4;
  localparam logic [LVL_W-1:0] RST_PEAK_STEP = 8'd2;
  localparam logic [31:0]      RST_SENS_LOW  = 32'h2828_2832;
  localparam logic [31:0]      RST_SENS_HIGH = 32'h1919_1919;

  // Upper bin edges of the bands; bins just above band 0 map to no band.
  localparam logic [9:0] EDGE_B0   = 10'd4;
  localparam logic [9:0] EDGE_GAP  = 10'd6;
  localparam logic [9:0] EDGE_B1   = 10'd10;
  localparam logic [9:0] EDGE_B2   = 10'd14;
  localparam logic [9:0] EDGE_B3   = 10'd30;
  localparam logic [9:0] EDGE_B4   = 10'd60;
  localparam logic [9:0] EDGE_B5   = 10'd106;
  localparam logic [9:0] EDGE_B6   = 10'd400;

  typedef struct packed {
    logic [1:0]       func;
    logic [9:0]       bin_index;
    logic [MAG_W-1:0] magnitude;
  } sbpm_in_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [LVL_W-1:0]  level;
    logic [LVL_W-1:0]  peak;
    logic              peak_changed;
    logic              last;
  } sbpm_out_t;

  typedef struct packed {
    logic load_item;
    logic tick;
    logic div_start;
    logic div_step;
    logic store_bin;
    logic fe_start;
    logic fe_test;
    logic fe_upd;
    logic fe_next;
  } sbpm_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       hit;
    logic       div_done;
    logic       band_last;
    logic       out_free;
  } sbpm_sts_t;

  // Returns {valid, band}; valid is low for bins that belong to no band.
  function automatic logic [BAND_W:0] map_bin(input logic [9:0] bin);
    logic [BAND_W:0] r;
    if (bin <= EDGE_B0)       r = {1'b1, 3'd0};
    else if (bin <= EDGE_GAP) r = {1'b0, 3'd0};
    else if (bin <= EDGE_B1)  r = {1'b1, 3'd1};
    else if (bin <= EDGE_B2)  r = {1'b1, 3'd2};
    else if (bin <= EDGE_B3)  r = {1'b1, 3'd3};
    else if (bin <= EDGE_B4)  r = {1'b1, 3'd4};
    else if (bin <= EDGE_B5)  r = {1'b1, 3'd5};
    else if (bin <= EDGE_B6)  r = {1'b1, 3'd6};
    else                      r = {1'b1, 3'd7};
    return r;
  endfunction

endpackage

### hdl/sbpm_dp.sv
// Datapath of the spectrum band peak meter: configuration registers, band
// state, radix-2 divider, frame-end update and the output register.
// Depends on sbpm_pkg.
`timescale 1ns / 1ps

module sbpm_dp
  import sbpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  sbpm_in_t             in_item_i,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  output sbpm_out_t            out_item_o,
  input  sbpm_cmd_t            cmd_i,
  output sbpm_sts_t            sts_o
);

  logic [MAG_W-1:0] noise_thr_q;
  logic [15:0]      timeout_q;
  logic [LVL_W-1:0] lvl_limit_q, lvl_step_q, peak_step_q;
  logic [31:0]      sens_low_q, sens_high_q;

  logic [1:0]        func_q;
  logic [MAG_W-1:0]  mag_q;
  logic [BAND_W-1:0] band_q;
  logic              band_vld_q;

  logic [LVL_W-1:0] level_q [NUM_BANDS];
  logic [LVL_W-1:0] peak_q  [NUM_BANDS];
  logic [LVL_W-1:0] shown_q [NUM_BANDS];
  logic [MS_W-1:0]  stamp_q [NUM_BANDS];
  logic [MS_W-1:0]  now_q;

  logic [MAG_W-1:0]     quot_q;
  logic [LVL_W-1:0]     rem_q, dvs_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  logic             idle_q;
  logic [LVL_W-1:0] lvnew_q;

  logic      out_valid_q;
  sbpm_out_t out_q;

  logic [BAND_W:0]  map_w;
  logic [31:0]      sens_word;
  logic [LVL_W-1:0] sens_byte;
  logic [LVL_W:0]   trial;
  logic             trial_ge;
  logic [LVL_W-1:0] bin_lvl;
  logic [LVL_W-1:0] cur_lvl, cur_peak, lvl_dec, lvl_clamp;
  logic [LVL_W-1:0] pk_raise, pk_new;
  logic [MS_W-1:0]  idle_ms;

  assign map_w     = map_bin(in_item_i.bin_index);
  assign sens_word = band_q[BAND_W-1] ? sens_high_q : sens_low_q;
  assign sens_byte = sens_word[{band_q[BAND_W-2:0], 3'b000} +: LVL_W];

  // One restoring division step: shift a dividend bit into the remainder.
  assign trial    = {rem_q, quot_q[MAG_W-1]};
  assign trial_ge = trial >= {1'b0, dvs_q};

  assign bin_lvl = (quot_q > {{(MAG_W-LVL_W){1'b0}}, lvl_limit_q}) ? lvl_limit_q
                                                                     : quot_q[LVL_W-1:0];

  assign cur_lvl   = level_q[band_q];
  assign cur_peak  = peak_q[band_q];
  assign idle_ms   = now_q - stamp_q[band_q];
  assign lvl_dec   = (cur_lvl > lvl_step_q) ? cur_lvl - lvl_step_q : '0;
  assign lvl_clamp = (lvl_dec > lvl_limit_q) ? lvl_limit_q : lvl_dec;
  assign pk_raise  = (idle_q && lvnew_q > cur_peak) ? lvnew_q : cur_peak;
  assign pk_new    = (pk_raise > peak_step_q) ? pk_raise - peak_step_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_thr_q <= RST_NOISE_THR;
      timeout_q   <= RST_TIMEOUT;
      lvl_limit_q <= RST_LVL_LIMIT;
      lvl_step_q  <= RST_LVL_STEP;
      peak_step_q <= RST_PEAK_STEP;
      sens_low_q  <= RST_SENS_LOW;
      sens_high_q <= RST_SENS_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NOISE_THR: noise_thr_q <= cfg_wdata_i[MAG_W-1:0];
        REG_TIMEOUT:   timeout_q   <= cfg_wdata_i[15:0];
        REG_LVL_LIMIT: lvl_limit_q <= cfg_wdata_i[LVL_W-1:0];
        REG_LVL_STEP:  lvl_step_q  <= cfg_wdata_i[LVL_W-1:0];
        REG_PEAK_STEP: peak_step_q <= cfg_wdata_i[LVL_W-1:0];
        REG_SENS_LOW:  sens_low_q  <= cfg_wdata_i;
        REG_SENS_HIGH: sens_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Item capture, band selection and divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_q     <= FUNC_BIN;
      band_q     <= '0;
      band_vld_q <= 1'b0;
      div_cnt_q  <= '0;
    end else begin
      if (cmd_i.load_item) begin
        func_q     <= in_item_i.func;
        band_q     <= map_w[BAND_W-1:0];
        band_vld_q <= map_w[BAND_W];
      end else if (cmd_i.fe_start) begin
        band_q <= '0;
      end else if (cmd_i.fe_next) begin
        band_q <= band_q + 1'b1;
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mag_q <= in_item_i.magnitude;
    end
    if (cmd_i.div_start) begin
      quot_q <= mag_q;
      rem_q  <= '0;
      dvs_q  <= (sens_byte == '0) ? 8'd1 : sens_byte;
    end else if (cmd_i.div_step) begin
      quot_q <= {quot_q[MAG_W-2:0], trial_ge};
      rem_q  <= trial_ge ? (trial[LVL_W-1:0] - dvs_q) : trial[LVL_W-1:0];
    end
    if (cmd_i.fe_test) begin
      idle_q  <= idle_ms > {{(MS_W-16){1'b0}}, timeout_q};
      lvnew_q <= lvl_clamp;
    end
  end

  // Band state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BANDS; i++) begin
        level_q[i] <= '0;
        peak_q[i]  <= '0;
        shown_q[i] <= '0;
        stamp_q[i] <= '0;
      end
      now_q <= '0;
    end else begin
      if (cmd_i.tick) begin
        now_q <= now_q + 1'b1;
      end
      if (cmd_i.store_bin) begin
        level_q[band_q] <= bin_lvl;
        stamp_q[band_q] <= now_q;
        if (bin_lvl > cur_peak) begin
          peak_q[band_q] <= bin_lvl;
        end
      end
      if (cmd_i.fe_upd) begin
        if (idle_q) begin
          level_q[band_q] <= lvnew_q;
          stamp_q[band_q] <= now_q;
        end
        peak_q[band_q]  <= pk_new;
        shown_q[band_q] <= pk_new;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fe_upd) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fe_upd) begin
      out_q.band         <= band_q;
      out_q.level        <= idle_q ? lvnew_q : cur_lvl;
      out_q.peak         <= pk_new;
      out_q.peak_changed <= shown_q[band_q] != pk_new;
      out_q.last         <= band_q == BAND_W'(NUM_BANDS - 1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign sts_o.func      = func_q;
  assign sts_o.hit       = band_vld_q && (mag_q > noise_thr_q);
  assign sts_o.div_done  = div_cnt_q == DIV_CNT_W'(MAG_W - 1);
  assign sts_o.band_last = band_q == BAND_W'(NUM_BANDS - 1);
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### hdl/sbpm_ctrl.sv
// Controller of the spectrum band peak meter: sequences item decode, the
// divider, bin stores and the frame-end walk. Depends on sbpm_pkg.
`timescale 1ns / 1ps

module sbpm_ctrl
  import sbpm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  sbpm_sts_t sts_i,
  output sbpm_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECODE  = 3'd1;
  localparam logic [2:0] S_DIV     = 3'd2;
  localparam logic [2:0] S_STORE   = 3'd3;
  localparam logic [2:0] S_FE_TEST = 3'd4;
  localparam logic [2:0] S_FE_UPD  = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.func)
          FUNC_BIN: begin
            if (sts_i.hit) begin
              cmd_o.div_start = 1'b1;
              state_d         = S_DIV;
            end else begin
              state_d = S_IDLE;
            end
          end
          FUNC_TICK: begin
            cmd_o.tick = 1'b1;
            state_d    = S_IDLE;
          end
          FUNC_FRAME: begin
            cmd_o.fe_start = 1'b1;
            state_d        = S_FE_TEST;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_STORE;
        end
      end
      S_STORE: begin
        cmd_o.store_bin = 1'b1;
        state_d         = S_IDLE;
      end
      S_FE_TEST: begin
        cmd_o.fe_test = 1'b1;
        if (sts_i.out_free) begin
          state_d = S_FE_UPD;
        end
      end
      S_FE_UPD: begin
        cmd_o.fe_upd = 1'b1;
        if (sts_i.band_last) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.fe_next = 1'b1;
          state_d       = S_FE_TEST;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  a_decode_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DECODE) |-> $past(in_valid_i && in_ready_o))
    else $error("decode entered without an input transfer");

  a_div_to_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_done) |=> (state_q == S_STORE))
    else $error("divider finished but the store step was skipped");

  a_upd_needs_free_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FE_UPD) |-> $past(sts_i.out_free))
    else $error("band update entered while the output register was occupied");
`endif

endmodule

### hdl/spectrum_band_peak_meter.sv
// Spectrum band peak meter. A bin item in a band above the noise threshold
// is decoded, run through 24 radix-2 divider steps and stored; then ready
// returns. A frame end tests and then updates each band in turn, loading
// each result while the output is free; ready returns after the last band.
// The 24-step divider sets the bin rate. Asynchronous active-low reset
// restores register defaults and clears all band state and the ms counter.
`timescale 1ns / 1ps

module spectrum_band_peak_meter
  import sbpm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sbpm_in_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sbpm_out_t            out_item_o
);

  // The controller accepts one item at a time. A bin item in a band and above
  // the noise threshold runs the shared divider one quotient bit per cycle,
  // then the clamped quotient is written to the band level, may raise the
  // peak, and restamps the band time.
  // A frame end walks the eight bands, each with a test and an update step:
  // the first tests the idle time and computes the decayed level, the second
  // writes the level of an idle band, peak and shown peak and loads the result
  // into the output register. A result waiting there holds up only the walk.

  sbpm_cmd_t cmd;
  sbpm_sts_t sts;

  sbpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbpm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

### sim/tb.sv
// Self-checking testbench for the spectrum band peak meter.
// Depends on hdl/sbpm_pkg.sv and hdl/spectrum_band_peak_meter.sv with its submodules.
`timescale 1ns / 1ps

module tb;
  import sbpm_pkg::*;

  // The unused function code; the meter must ignore it.
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // Clock, reset and every block input start at known values.
  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic            in_valid_i  = 1'b0;
  logic            in_ready_o;
  sbpm_in_t        in_item_i   = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  sbpm_out_t       out_item_o;

  spectrum_band_peak_meter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Items waiting to be offered, and band rows the meter should produce.
  sbpm_in_t  pending_q[$];
  sbpm_out_t band_rows_q[$];

  // Run bookkeeping.
  int errors        = 0;
  int items_taken   = 0;
  int frames_taken  = 0;
  int rows_checked  = 0;
  int settings_used = 0;
  bit quiet         = 1'b0;  // no idling on either side once set
  bit hold_armed    = 1'b0;  // asks the receiver for one long hold-off

  // Shadow copy of the configuration registers.
  logic [23:0] thr_c;
  logic [15:0] tmo_c;
  logic [7:0]  lim_c;
  logic [7:0]  lstep_c;
  logic [7:0]  pstep_c;
  logic [31:0] sens_lo_c;
  logic [31:0] sens_hi_c;

  // Shadow copy of the per-band state and the millisecond counter.
  logic [7:0]  lvl_m   [NUM_BANDS];
  logic [7:0]  pk_m    [NUM_BANDS];
  logic [7:0]  shown_m [NUM_BANDS];
  logic [31:0] stamp_m [NUM_BANDS];
  logic [31:0] ms_now;

  // Inclusive bin ranges per band; bins 5 and 6 sit in the gap.
  int band_lo[NUM_BANDS] = '{0, 7, 11, 15, 31, 61, 107, 401};
  int band_hi[NUM_BANDS] = '{4, 10, 14, 30, 60, 106, 400, 1023};

  task automatic note_error(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  // Band that a bin belongs to, or -1 for the gap between band 0 and band 1.
  function automatic int band_of_bin(input logic [9:0] bin);
    if (bin <= EDGE_B0)  return 0;
    if (bin <= EDGE_GAP) return -1;
    if (bin <= EDGE_B1)  return 1;
    if (bin <= EDGE_B2)  return 2;
    if (bin <= EDGE_B3)  return 3;
    if (bin <= EDGE_B4)  return 4;
    if (bin <= EDGE_B5)  return 5;
    if (bin <= EDGE_B6)  return 6;
    return 7;
  endfunction

  // Writes a new band level: clamped to the limit, may raise the peak, and
  // restamps the band with the current millisecond count.
  task automatic set_band_level(input int b, input logic [23:0] v);
    logic [23:0] lv;
    lv = (v > {16'd0, lim_c}) ? {16'd0, lim_c} : v;
    if (lv > {16'd0, pk_m[b]}) pk_m[b] = lv[7:0];
    lvl_m[b]   = lv[7:0];
    stamp_m[b] = ms_now;
  endtask

  // Applies one accepted input item to the shadow state; a frame end queues
  // the eight band rows it must produce.
  task automatic meter_accept(input sbpm_in_t it);
    int          b;
    logic [7:0]  dv;
    logic [31:0] idle;
    logic [7:0]  pk;
    sbpm_out_t   row;
    case (it.func)
      FUNC_BIN: begin
        b = band_of_bin(it.bin_index);
        if (it.magnitude > thr_c && b >= 0) begin
          dv = (b < 4) ? sens_lo_c[8*(b%4) +: 8] : sens_hi_c[8*(b%4) +: 8];
          if (dv == 8'd0) dv = 8'd1;
          set_band_level(b, it.magnitude / dv);
        end
      end
      FUNC_TICK: ms_now = ms_now + 32'd1;
      FUNC_FRAME: begin
        frames_taken++;
        for (b = 0; b < NUM_BANDS; b++) begin
          idle = ms_now - stamp_m[b];
          if (idle > {16'd0, tmo_c})
            set_band_level(b, (lvl_m[b] > lstep_c) ? lvl_m[b] - lstep_c : 24'd0);
          pk = pk_m[b];
          if (pk != 8'd0) pk = (pk > pstep_c) ? pk - pstep_c : 8'd0;
          pk_m[b]          = pk;
          row.band         = b[BAND_W-1:0];
          row.level        = lvl_m[b];
          row.peak         = pk;
          row.peak_changed = (shown_m[b] != pk);
          row.last         = (b == NUM_BANDS - 1);
          shown_m[b]       = pk;
          band_rows_q.push_back(row);
        end
      end
      default: ;  // the spare function code leaves everything untouched
    endcase
  endtask

  // Driver: offers queued items, holding valid and payload steady until the
  // transfer happens. Gaps are only opened while no item is on offer.
  int src_gap = 0;

  always @(posedge clk_i) begin : drive_items
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        meter_accept(in_item_i);
        items_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
          src_gap = $urandom_range(0, 3);
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_valid_i <= 1'b1;
          in_item_i  <= pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness: short random stalls, plus one long hold-off on
  // request. The hold-off is counted here so the sender keeps offering items
  // while the output side is blocked and the meter backs up into its input.
  int sink_stall = 0;
  int hold_left  = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk_i) begin : drive_ready
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_done = 1'b1;
      hold_left = 250;
      out_ready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (sink_stall > 0) begin
      sink_stall--;
      out_ready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      sink_stall = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Monitor: every result transfer is checked against the oldest band row.
  always @(posedge clk_i) begin : check_rows
    sbpm_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (band_rows_q.size() == 0) begin
        note_error($sformatf("result for band %0d with nothing expected",
                             out_item_o.band));
      end else begin
        want = band_rows_q.pop_front();
        rows_checked++;
        if (out_item_o.band !== want.band)
          note_error($sformatf("band: got %0d want %0d", out_item_o.band, want.band));
        if (out_item_o.level !== want.level)
          note_error($sformatf("band %0d level: got %0d want %0d",
                               want.band, out_item_o.level, want.level));
        if (out_item_o.peak !== want.peak)
          note_error($sformatf("band %0d peak: got %0d want %0d",
                               want.band, out_item_o.peak, want.peak));
        if (out_item_o.peak_changed !== want.peak_changed)
          note_error($sformatf("band %0d peak_changed: got %b want %b",
                               want.band, out_item_o.peak_changed, want.peak_changed));
        if (out_item_o.last !== want.last)
          note_error($sformatf("band %0d last: got %b want %b",
                               want.band, out_item_o.last, want.last));
      end
    end
  end

  // Register write through the plain write port; the shadow copy follows.
  // Only called while the meter is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_NOISE_THR: thr_c     = val[23:0];
      REG_TIMEOUT:   tmo_c     = val[15:0];
      REG_LVL_LIMIT: lim_c     = val[7:0];
      REG_LVL_STEP:  lstep_c   = val[7:0];
      REG_PEAK_STEP: pstep_c   = val[7:0];
      REG_SENS_LOW:  sens_lo_c = val;
      REG_SENS_HIGH: sens_hi_c = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [23:0] thr, input logic [15:0] tmo,
                         input logic [7:0] lim, input logic [7:0] lstep,
                         input logic [7:0] pstep, input logic [31:0] slo,
                         input logic [31:0] shi);
    cfg_write(REG_NOISE_THR, {8'd0, thr});
    cfg_write(REG_TIMEOUT,   {16'd0, tmo});
    cfg_write(REG_LVL_LIMIT, {24'd0, lim});
    cfg_write(REG_LVL_STEP,  {24'd0, lstep});
    cfg_write(REG_PEAK_STEP, {24'd0, pstep});
    cfg_write(REG_SENS_LOW,  slo);
    cfg_write(REG_SENS_HIGH, shi);
    settings_used++;
  endtask

  task automatic push_item(input logic [1:0] func, input logic [9:0] bin,
                           input logic [23:0] mag);
    sbpm_in_t it;
    it.func      = func;
    it.bin_index = bin;
    it.magnitude = mag;
    pending_q.push_back(it);
  endtask

  // Random items: mostly bins and ticks with a steady sprinkling of frame
  // ends and spare codes. Bins are often picked inside one band's range, and
  // magnitudes often sit right at the noise threshold.
  task automatic queue_random(input int n);
    int          k;
    int          sel;
    int          b;
    logic [9:0]  bin;
    logic [24:0] near;
    logic [23:0] mag;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 3) begin
        push_item(FUNC_SPARE, 10'($urandom_range(0, 1023)), 24'($urandom));
      end else if (sel < 15) begin
        push_item(FUNC_FRAME, 10'($urandom_range(0, 1023)), 24'($urandom));
      end else if (sel < 45) begin
        push_item(FUNC_TICK, 10'($urandom_range(0, 1023)), 24'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0: bin = 10'($urandom_range(0, 1023));
          1: bin = 10'($urandom_range(5, 6));
          default: begin
            b   = $urandom_range(0, NUM_BANDS - 1);
            bin = 10'($urandom_range(band_lo[b], band_hi[b]));
          end
        endcase
        case ($urandom_range(0, 3))
          0: mag = 24'($urandom);
          1: begin
            near = 25'({1'b0, thr_c} + $urandom_range(0, 2));
            mag  = (near == 25'd0) ? 24'd0 :
                   (near > 25'hFFFFFF) ? 24'hFFFFFF : near[23:0] - 24'd1;
          end
          default: mag = 24'($urandom_range(0, 16000));
        endcase
        push_item(FUNC_BIN, bin, mag);
      end
    end
  endtask

  // Waits until every item has gone in and every row has come out, then
  // waits further so that a trailing bin update has finished before the
  // registers are touched.
  task automatic drain();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || in_valid_i || band_rows_q.size() != 0);
    repeat (40) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int b;
    thr_c     = RST_NOISE_THR;
    tmo_c     = RST_TIMEOUT;
    lim_c     = RST_LVL_LIMIT;
    lstep_c   = RST_LVL_STEP;
    pstep_c   = RST_PEAK_STEP;
    sens_lo_c = RST_SENS_LOW;
    sens_hi_c = RST_SENS_HIGH;
    for (b = 0; b < NUM_BANDS; b++) begin
      lvl_m[b]   = '0;
      pk_m[b]    = '0;
      shown_m[b] = '0;
      stamp_m[b] = '0;
    end
    ms_now = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset register values: every band edge, the gap
    // bins, a magnitude that only equals the threshold, a zero magnitude,
    // the largest magnitude (clamped to the limit), ticks, the spare
    // function code, and two frame ends in a row so the peak decays twice.
    settings_used++;
    push_item(FUNC_BIN, 10'd0,    24'hFFFFFF);
    push_item(FUNC_BIN, 10'd4,    24'd1000);
    push_item(FUNC_BIN, 10'd5,    24'hFFFFFF);
    push_item(FUNC_BIN, 10'd6,    24'hFFFFFF);
    push_item(FUNC_BIN, 10'd7,    24'd500);
    push_item(FUNC_BIN, 10'd10,   24'd501);
    push_item(FUNC_BIN, 10'd11,   24'd4000);
    push_item(FUNC_BIN, 10'd14,   24'd2400);
    push_item(FUNC_BIN, 10'd15,   24'd7000);
    push_item(FUNC_BIN, 10'd30,   24'd1200);
    push_item(FUNC_BIN, 10'd31,   24'd3000);
    push_item(FUNC_BIN, 10'd60,   24'd999);
    push_item(FUNC_BIN, 10'd61,   24'h800000);
    push_item(FUNC_BIN, 10'd106,  24'd2600);
    push_item(FUNC_BIN, 10'd107,  24'd1500);
    push_item(FUNC_BIN, 10'd400,  24'd4500);
    push_item(FUNC_BIN, 10'd401,  24'd600);
    push_item(FUNC_BIN, 10'd1023, 24'd5000);
    push_item(FUNC_BIN, 10'd3,    24'd0);
    push_item(FUNC_TICK, 10'd0,   24'd0);
    push_item(FUNC_TICK, 10'h3FF, 24'hFFFFFF);
    push_item(FUNC_SPARE, 10'h3FF, 24'hFFFFFF);
    push_item(FUNC_FRAME, 10'd0,  24'd0);
    push_item(FUNC_FRAME, 10'h3FF, 24'hFFFFFF);
    drain();

    // Lowest threshold, zero timeout so idle decay starts after one tick,
    // widest limit and steps; zero divisors low, largest divisors high.
    cfg_all(24'd0, 16'd0, 8'd255, 8'd255, 8'd255, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_random(70);
    drain();

    // Opposite extremes: nothing clears the threshold, zero limit and steps,
    // longest timeout.
    cfg_all(24'hFFFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd0, 32'h0102_0304, 32'h8040_2010);
    push_item(FUNC_BIN, 10'd200, 24'hFFFFFF);
    queue_random(20);
    push_item(FUNC_FRAME, 10'd0, 24'd0);
    drain();

    // Mid-range random settings under back-pressure: the receiver holds off
    // for a long stretch while frame ends keep arriving.
    cfg_all(24'($urandom_range(0, 3000)), 16'($urandom_range(0, 8)), 8'($urandom),
            8'($urandom_range(0, 40)), 8'($urandom_range(0, 20)), $urandom, $urandom);
    hold_armed = 1'b1;
    push_item(FUNC_BIN, 10'd20, 24'd9000);
    push_item(FUNC_FRAME, 10'd0, 24'd0);
    push_item(FUNC_FRAME, 10'd0, 24'd0);
    push_item(FUNC_BIN, 10'd500, 24'd7000);
    push_item(FUNC_FRAME, 10'd0, 24'd0);
    queue_random(90);
    drain();

    // Final stretch with no idling on either side.
    quiet = 1'b1;
    cfg_all(24'd300, 16'd3, 8'd180, 8'd6, 8'd3, 32'h0A14_1E28, 32'h0005_0F32);
    queue_random(70);
    drain();

    $display("Covered %0d input transfers with %0d frame ends, checking %0d band rows",
             items_taken, frames_taken, rows_checked);
    $display("across %0d register settings, including a long output hold-off.",
             settings_used);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("Timeout with %0d items queued and %0d rows outstanding",
             pending_q.size(), band_rows_q.size());
    $display("tb NOT OK");
    $finish;
  end

endmodule

### files.f
hdl/sbpm_pkg.sv
hdl/sbpm_dp.sv
hdl/sbpm_ctrl.sv
hdl/spectrum_band_peak_meter.sv
sim/tb.sv
